@@ design/toab_pkg.sv @@
// Package for the text overlay blend unit: request and result structs,
// register indexes, alignment codes, shade table and divide constants.
// No dependencies.
package toab_pkg;

	localparam int WIN_W      = 12;
	localparam int TEXT_W_W   = 9;
	localparam int TEXT_R_W   = 6;
	localparam int ALIGN_W    = 3;
	localparam int BLEND_W    = 7;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int COORD_W    = 11;
	localparam int CHAN_W     = 8;
	localparam int CODE_W     = 3;
	localparam int POS_W      = 13;
	localparam int SUM_W      = 16;

	localparam int MAX_TEXT_WIDTH_DEF = 256;
	localparam int MAX_TEXT_ROWS_DEF  = 32;

	localparam logic [WIN_W-1:0]   WINDOW_WIDTH_RST  = 12'd640;
	localparam logic [WIN_W-1:0]   WINDOW_HEIGHT_RST = 12'd480;
	localparam logic [BLEND_W-1:0] BLEND_RST         = 7'd50;
	localparam logic [BLEND_W-1:0] BLEND_FULL        = 7'd100;

	// floor(x / 100) == (x * 5243) >> 19 for every x below 43690
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	localparam logic [CODE_W-1:0] CODE_MAX_GRAY = 3'd3;
	localparam logic [CODE_W-1:0] CODE_BLACK    = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_WIDTH  = 3'd0,
		REG_WINDOW_HEIGHT = 3'd1,
		REG_TEXT_WIDTH    = 3'd2,
		REG_TEXT_ROWS     = 3'd3,
		REG_ALIGN_MODE    = 3'd4,
		REG_BLEND_PERCENT = 3'd5
	} cfg_reg_t;

	typedef enum logic [ALIGN_W-1:0] {
		ALIGN_TOP_LEFT     = 3'd0,
		ALIGN_TOP_RIGHT    = 3'd1,
		ALIGN_BOTTOM_LEFT  = 3'd2,
		ALIGN_BOTTOM_RIGHT = 3'd3,
		ALIGN_TOP_CENTRE   = 3'd4,
		ALIGN_BOTTOM_CENTRE = 3'd5
	} align_t;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	typedef struct packed {
		logic               func;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [7:0]         glyph_value;
		logic [CHAN_W-1:0]  chan0_in;
		logic [CHAN_W-1:0]  chan1_in;
		logic [CHAN_W-1:0]  chan2_in;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan0_out;
		logic [CHAN_W-1:0] chan1_out;
		logic [CHAN_W-1:0] chan2_out;
		logic              in_text;
	} out_item_t;

	// gray code to shade; black and codes above it give 0
	function automatic logic [CHAN_W-1:0] shade_of(input logic [CODE_W-1:0] code);
		logic [CHAN_W-1:0] s;
		case (code)
			3'd0: s = 8'd255;
			3'd1: s = 8'd220;
			3'd2: s = 8'd162;
			3'd3: s = 8'd64;
			default: s = 8'd0;
		endcase
		return s;
	endfunction

endpackage

@@ design/text_overlay_alpha_blend_unit.sv @@
// Text overlay blend unit: glyph bitmap store, placement logic and
// per-channel alpha blend pipeline. Depends on toab_pkg.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries requests. A load
//   request (func = FUNC_LOAD) writes one glyph entry and gives no result;
//   a pixel request gives exactly one result on out_valid / out_stall /
//   out_data, in request order.
//   Configuration is written through cfg_we / cfg_index / cfg_data while
//   no request is in flight.
//   A pixel passes the input register, the glyph store read, the blend
//   products and the divide by 100 before it shows on out_valid.
//   Throughput: one request per cycle unless out_stall holds; the glyph store
//   is one array with a single port, written or read once per cycle by the
//   request in stage 1. Each stage moves on when its successor is empty or
//   moving, so a result waiting in the output register does not stop new
//   requests from filling the empty stages behind it; in_stall rises only
//   when every stage holds a request.
//   Reset clears valid bits and returns config/placement regs to defaults.
//   The glyph store is not cleared: entries read back only after a load.
module text_overlay_alpha_blend_unit #(
	parameter int MAX_TEXT_WIDTH = toab_pkg::MAX_TEXT_WIDTH_DEF,
	parameter int MAX_TEXT_ROWS  = toab_pkg::MAX_TEXT_ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  toab_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output toab_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [toab_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [toab_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import toab_pkg::*;

	localparam int DEPTH = MAX_TEXT_WIDTH * MAX_TEXT_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_TEXT_WIDTH);
	localparam int RW    = $clog2(MAX_TEXT_ROWS);

	// configuration registers
	logic [WIN_W-1:0]    window_width_q, window_height_q;
	logic [TEXT_W_W-1:0] text_width_q;
	logic [TEXT_R_W-1:0] text_rows_q;
	logic [ALIGN_W-1:0]  align_mode_q;
	logic [BLEND_W-1:0]  blend_percent_q;

	// placement derived from configuration
	logic [WIN_W-1:0]   tw_d, tr_d, xo_d, yo_d, tr_q, xo_q, yo_q;
	logic [POS_W-1:0]   xe_q, ye_q;
	logic [BLEND_W-1:0] b_d, b_q, inv_q;

	// pipeline
	logic         v_s1, v_s2, v_s3;
	in_item_t     req_s1;
	logic         ld_s1, ld_s2, ld_s3, ld_out;
	logic         inside_s2, inside_s3;
	logic [CHAN_W-1:0] ch0_s2, ch1_s2, ch2_s2, ch0_s3, ch1_s3, ch2_s3;
	logic [CODE_W-1:0] code_s2;
	logic [SUM_W-1:0]  sum0_s3, sum1_s3, sum2_s3;
	logic [SUM_W-1:0]  sum0_d, sum1_d, sum2_d;
	logic              out_valid_q;
	out_item_t         out_q;

	// stage 1 placement signals
	logic [POS_W-1:0]  col_x, row_x, rel_x, rel_y, ridx;
	logic              inside_s1, load_ok;
	logic [AW-1:0]     addr_s1;
	logic [CODE_W-1:0] wcode;
	logic              mem_we, mem_re;

	logic [CODE_W-1:0] glyph_mem [DEPTH];

	// handshake
	assign ld_out   = !out_valid_q || !out_stall;
	assign ld_s3    = !v_s3 || ld_out;
	assign ld_s2    = !v_s2 || ld_s3;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_stall = !ld_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_width_q  <= WINDOW_WIDTH_RST;
			window_height_q <= WINDOW_HEIGHT_RST;
			text_width_q    <= '0;
			text_rows_q     <= '0;
			align_mode_q    <= ALIGN_TOP_LEFT;
			blend_percent_q <= BLEND_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WINDOW_WIDTH:  window_width_q  <= cfg_data[WIN_W-1:0];
				REG_WINDOW_HEIGHT: window_height_q <= cfg_data[WIN_W-1:0];
				REG_TEXT_WIDTH:    text_width_q    <= cfg_data[TEXT_W_W-1:0];
				REG_TEXT_ROWS:     text_rows_q     <= cfg_data[TEXT_R_W-1:0];
				REG_ALIGN_MODE:    align_mode_q    <= cfg_data[ALIGN_W-1:0];
				REG_BLEND_PERCENT: blend_percent_q <= cfg_data[BLEND_W-1:0];
				default: ;
			endcase
		end
	end

	// clip text to window and store, then place it; clamp the blend percent
	always_comb begin
		logic [WIN_W-1:0] tw_a, tr_a, cx;
		tw_a = (WIN_W'(text_width_q) < window_width_q) ? WIN_W'(text_width_q)
			: window_width_q;
		tw_d = (tw_a < WIN_W'(MAX_TEXT_WIDTH)) ? tw_a : WIN_W'(MAX_TEXT_WIDTH);
		tr_a = (WIN_W'(text_rows_q) < window_height_q) ? WIN_W'(text_rows_q)
			: window_height_q;
		tr_d = (tr_a < WIN_W'(MAX_TEXT_ROWS)) ? tr_a : WIN_W'(MAX_TEXT_ROWS);
		cx   = (window_width_q >> 1) - (tw_d >> 1);
		case (align_t'(align_mode_q))
			ALIGN_TOP_RIGHT: begin
				xo_d = window_width_q - tw_d;
				yo_d = '0;
			end
			ALIGN_BOTTOM_LEFT: begin
				xo_d = '0;
				yo_d = window_height_q - tr_d;
			end
			ALIGN_BOTTOM_RIGHT: begin
				xo_d = window_width_q - tw_d;
				yo_d = window_height_q - tr_d;
			end
			ALIGN_TOP_CENTRE: begin
				xo_d = cx;
				yo_d = '0;
			end
			ALIGN_BOTTOM_CENTRE: begin
				xo_d = cx;
				yo_d = window_height_q - tr_d;
			end
			default: begin
				xo_d = '0;
				yo_d = '0;
			end
		endcase
		b_d = (blend_percent_q > BLEND_FULL) ? BLEND_FULL : blend_percent_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tr_q  <= '0;
			xo_q  <= '0;
			yo_q  <= '0;
			xe_q  <= '0;
			ye_q  <= '0;
			b_q   <= BLEND_RST;
			inv_q <= BLEND_FULL - BLEND_RST;
		end else begin
			tr_q  <= tr_d;
			xo_q  <= xo_d;
			yo_q  <= yo_d;
			xe_q  <= POS_W'(xo_d) + POS_W'(tw_d);
			ye_q  <= POS_W'(yo_d) + POS_W'(tr_d);
			b_q   <= b_d;
			inv_q <= BLEND_FULL - b_d;
		end
	end

	// stage 1: area test and store address
	always_comb begin
		col_x     = POS_W'(req_s1.col);
		row_x     = POS_W'(req_s1.row);
		inside_s1 = (col_x >= POS_W'(xo_q)) && (col_x < xe_q)
			&& (row_x >= POS_W'(yo_q)) && (row_x < ye_q);
		rel_x     = col_x - POS_W'(xo_q);
		rel_y     = row_x - POS_W'(yo_q);
		// bitmap rows are stored top-down but read bottom-up
		ridx      = POS_W'(tr_q) - POS_W'(1) - rel_y;
		load_ok   = (32'(req_s1.col) < MAX_TEXT_WIDTH)
			&& (32'(req_s1.row) < MAX_TEXT_ROWS);
		if (req_s1.func == FUNC_LOAD) begin
			addr_s1 = AW'(req_s1.row[RW-1:0]) * AW'(MAX_TEXT_WIDTH)
				+ AW'(req_s1.col[CW-1:0]);
		end else begin
			addr_s1 = AW'(ridx[RW-1:0]) * AW'(MAX_TEXT_WIDTH) + AW'(rel_x[CW-1:0]);
		end
		wcode  = (req_s1.glyph_value > 8'(CODE_MAX_GRAY)) ? CODE_BLACK
			: req_s1.glyph_value[CODE_W-1:0];
		mem_we = v_s1 && ld_s2 && (req_s1.func == FUNC_LOAD) && load_ok;
		mem_re = v_s1 && ld_s2 && (req_s1.func == FUNC_PIXEL);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			glyph_mem[addr_s1] <= wcode;
		end
		if (mem_re) begin
			code_s2 <= glyph_mem[addr_s1];
		end
	end

	// stage 2: shade and pixel products
	always_comb begin
		logic [SUM_W-1:0] sb;
		sb     = SUM_W'(shade_of(code_s2)) * SUM_W'(b_q);
		sum0_d = sb + SUM_W'(ch0_s2) * SUM_W'(inv_q);
		sum1_d = sb + SUM_W'(ch1_s2) * SUM_W'(inv_q);
		sum2_d = sb + SUM_W'(ch2_s2) * SUM_W'(inv_q);
	end

	// stage 3: divide by 100 through the reciprocal
	function automatic logic [CHAN_W-1:0] div100(input logic [SUM_W-1:0] x);
		logic [SUM_W+12:0] p;
		p = (SUM_W+13)'(x) * (SUM_W+13)'(RECIP_100);
		return p[RECIP_SHIFT +: CHAN_W];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= in_valid;
			end
			if (ld_s2) begin
				v_s2 <= v_s1 && (req_s1.func == FUNC_PIXEL);
			end
			if (ld_s3) begin
				v_s3 <= v_s2;
			end
			if (ld_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid) begin
			req_s1 <= in_data;
		end
		if (ld_s2) begin
			inside_s2 <= inside_s1;
			ch0_s2    <= req_s1.chan0_in;
			ch1_s2    <= req_s1.chan1_in;
			ch2_s2    <= req_s1.chan2_in;
		end
		if (ld_s3) begin
			inside_s3 <= inside_s2;
			ch0_s3    <= ch0_s2;
			ch1_s3    <= ch1_s2;
			ch2_s3    <= ch2_s2;
			sum0_s3   <= sum0_d;
			sum1_s3   <= sum1_d;
			sum2_s3   <= sum2_d;
		end
		if (ld_out) begin
			out_q.in_text   <= inside_s3;
			out_q.chan0_out <= inside_s3 ? div100(sum0_s3) : ch0_s3;
			out_q.chan1_out <= inside_s3 ? div100(sum1_s3) : ch1_s3;
			out_q.chan2_out <= inside_s3 ? div100(sum2_s3) : ch2_s3;
		end
	end

endmodule

@@ bench/tb_text_overlay_alpha_blend_unit.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the text overlay blend unit: glyph loads and pixel requests
// against a local prediction of placement, clipping and blending.
// Depends on toab_pkg and text_overlay_alpha_blend_unit.
module tb_text_overlay_alpha_blend_unit;
	import toab_pkg::*;

	localparam int STORE_W     = MAX_TEXT_WIDTH_DEF;
	localparam int STORE_R     = MAX_TEXT_ROWS_DEF;
	localparam int STORE_DEPTH = STORE_W * STORE_R;
	localparam int COORD_MAX   = (1 << COORD_W) - 1;
	localparam int PHASE_ITEMS = 118;
	localparam int DRAIN_WAIT  = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int PRINT_CAP   = 50;

	// modes with no name in the package; both fall back to top-left
	localparam logic [ALIGN_W-1:0] ALIGN_SPARE_6 = 3'd6;
	localparam logic [ALIGN_W-1:0] ALIGN_SPARE_7 = 3'd7;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// register shadow, changed only while the unit is idle
	logic [WIN_W-1:0]    win_w     = WINDOW_WIDTH_RST;
	logic [WIN_W-1:0]    win_h     = WINDOW_HEIGHT_RST;
	logic [TEXT_W_W-1:0] txt_w     = '0;
	logic [TEXT_R_W-1:0] txt_r     = '0;
	logic [ALIGN_W-1:0]  place_mode = ALIGN_TOP_LEFT;
	logic [BLEND_W-1:0]  blend_pct = BLEND_RST;

	logic [CODE_W-1:0] glyph_codes [STORE_DEPTH];
	bit                glyph_loaded [STORE_DEPTH];
	int unsigned       shade_table [5];

	in_item_t  pending_requests [$];
	out_item_t expected_pixels [$];
	out_item_t next_pixel;

	int  mismatches     = 0;
	int  accepted_count = 0;
	int  quiet_cycles   = 0;
	bit  req_taken      = 1'b0;
	bit  res_taken;
	logic calm;

	// one long stretch with no idling on either side
	assign calm = accepted_count >= 700 && accepted_count < 1100;

	text_overlay_alpha_blend_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// clipped text size and its offset in the window
	function automatic void area_of(output int unsigned xo, yo, tw, tr);
		tw = (txt_w < win_w) ? 32'(txt_w) : 32'(win_w);
		if (tw > STORE_W)
			tw = STORE_W;
		tr = (txt_r < win_h) ? 32'(txt_r) : 32'(win_h);
		if (tr > STORE_R)
			tr = STORE_R;
		xo = 0;
		yo = 0;
		case (place_mode)
			ALIGN_TOP_RIGHT: xo = win_w - tw;
			ALIGN_BOTTOM_LEFT: yo = win_h - tr;
			ALIGN_BOTTOM_RIGHT: begin
				xo = win_w - tw;
				yo = win_h - tr;
			end
			ALIGN_TOP_CENTRE: xo = win_w / 2 - tw / 2;
			ALIGN_BOTTOM_CENTRE: begin
				xo = win_w / 2 - tw / 2;
				yo = win_h - tr;
			end
			default: ;
		endcase
	endfunction

	// bitmap rows are read bottom-up
	function automatic bit glyph_index(input int unsigned c, r, output int unsigned idx);
		int unsigned xo, yo, tw, tr;
		area_of(xo, yo, tw, tr);
		idx = 0;
		if (c < xo || c >= xo + tw || r < yo || r >= yo + tr)
			return 1'b0;
		idx = (tr - 1 - (r - yo)) * STORE_W + (c - xo);
		return 1'b1;
	endfunction

	function automatic logic [CHAN_W-1:0] mix_channel(int unsigned shade, pix, b);
		int unsigned sum;
		sum = (shade * b + pix * (100 - b)) / 100;
		return sum[CHAN_W-1:0];
	endfunction

	function automatic out_item_t blend_result(in_item_t req);
		out_item_t   res;
		int unsigned idx, b, shade;
		res.chan0_out = req.chan0_in;
		res.chan1_out = req.chan1_in;
		res.chan2_out = req.chan2_in;
		res.in_text   = 1'b0;
		if (glyph_index(req.col, req.row, idx)) begin
			b = (blend_pct > BLEND_FULL) ? 32'(BLEND_FULL) : 32'(blend_pct);
			shade = shade_table[glyph_codes[idx]];
			res.chan0_out = mix_channel(shade, 32'(req.chan0_in), b);
			res.chan1_out = mix_channel(shade, 32'(req.chan1_in), b);
			res.chan2_out = mix_channel(shade, 32'(req.chan2_in), b);
			res.in_text   = 1'b1;
		end
		return res;
	endfunction

	task automatic apply_request(in_item_t req);
		if (req.func == FUNC_LOAD) begin
			if (req.col < STORE_W && req.row < STORE_R)
				glyph_codes[req.row * STORE_W + req.col] =
					(req.glyph_value > CODE_MAX_GRAY) ? CODE_BLACK : req.glyph_value[CODE_W-1:0];
		end else begin
			expected_pixels.push_back(blend_result(req));
		end
	endtask

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (mismatches < PRINT_CAP)
			$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic logic [CHAN_W-1:0] rand_chan();
		int unsigned p;
		p = $urandom_range(0, 9);
		if (p == 0)
			return 8'd0;
		if (p == 1)
			return 8'd255;
		return CHAN_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] rand_gray();
		if ($urandom_range(0, 9) < 8)
			return 8'($urandom_range(0, 5));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic push_load(int unsigned c, r, logic [7:0] v);
		in_item_t req;
		req.func        = FUNC_LOAD;
		req.col         = COORD_W'(c);
		req.row         = COORD_W'(r);
		req.glyph_value = v;
		req.chan0_in    = rand_chan();
		req.chan1_in    = rand_chan();
		req.chan2_in    = rand_chan();
		pending_requests.push_back(req);
		if (c < STORE_W && r < STORE_R)
			glyph_loaded[r * STORE_W + c] = 1'b1;
	endtask

	// load the entry first where the pixel would read one never written
	task automatic push_pixel(int unsigned c, r, logic [CHAN_W-1:0] c0, c1, c2);
		in_item_t    req;
		int unsigned idx;
		if (glyph_index(c, r, idx) && !glyph_loaded[idx])
			push_load(idx % STORE_W, idx / STORE_W, rand_gray());
		req.func        = FUNC_PIXEL;
		req.col         = COORD_W'(c);
		req.row         = COORD_W'(r);
		req.glyph_value = 8'($urandom_range(0, 255));
		req.chan0_in    = c0;
		req.chan1_in    = c1;
		req.chan2_in    = c2;
		pending_requests.push_back(req);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
	endtask

	// wait for every request and result, then for loads still in the pipe
	task automatic drain();
		while (pending_requests.size() != 0 || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_config(int unsigned w, h, tw, tr, mode, b);
		drain();
		write_reg(REG_WINDOW_WIDTH, w);
		write_reg(REG_WINDOW_HEIGHT, h);
		write_reg(REG_TEXT_WIDTH, tw);
		write_reg(REG_TEXT_ROWS, tr);
		write_reg(REG_ALIGN_MODE, mode);
		write_reg(REG_BLEND_PERCENT, b);
		@(negedge clk);
		cfg_we <= 1'b0;
		win_w      = w[WIN_W-1:0];
		win_h      = h[WIN_W-1:0];
		txt_w      = tw[TEXT_W_W-1:0];
		txt_r      = tr[TEXT_R_W-1:0];
		place_mode = mode[ALIGN_W-1:0];
		blend_pct  = b[BLEND_W-1:0];
		@(posedge clk);
	endtask

	// glyph loads and pixels: mostly pixels inside the placed area, some on its border, some anywhere
	task automatic fill_phase(int n);
		int unsigned xo, yo, tw, tr, x_hi, y_hi, pick;
		int          done;
		bit          reach;
		area_of(xo, yo, tw, tr);
		reach = tw != 0 && tr != 0 && xo <= COORD_MAX && yo <= COORD_MAX;
		x_hi = (xo + tw - 1 < COORD_MAX) ? xo + tw - 1 : COORD_MAX;
		y_hi = (yo + tr - 1 < COORD_MAX) ? yo + tr - 1 : COORD_MAX;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				// ignored by the unit: not counted
				if ($urandom_range(0, 1))
					push_load($urandom_range(STORE_W, COORD_MAX), $urandom_range(0, COORD_MAX),
						rand_gray());
				else
					push_load($urandom_range(0, COORD_MAX), $urandom_range(STORE_R, COORD_MAX),
						rand_gray());
			end else begin
				if (pick < 18 && reach)
					push_load($urandom_range(0, tw - 1), $urandom_range(0, tr - 1), rand_gray());
				else if (pick < 25)
					push_load($urandom_range(0, STORE_W - 1), $urandom_range(0, STORE_R - 1),
						rand_gray());
				else if (pick < 80 && reach)
					push_pixel($urandom_range(xo, x_hi), $urandom_range(yo, y_hi),
						rand_chan(), rand_chan(), rand_chan());
				else if (pick < 90 && reach)
					push_pixel($urandom_range((xo == 0) ? 0 : xo - 1,
							(x_hi < COORD_MAX) ? x_hi + 1 : COORD_MAX),
						$urandom_range((yo == 0) ? 0 : yo - 1,
							(y_hi < COORD_MAX) ? y_hi + 1 : COORD_MAX),
						rand_chan(), rand_chan(), rand_chan());
				else
					push_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
						rand_chan(), rand_chan(), rand_chan());
				done++;
			end
		end
	endtask

	// request driver: hold a stalled request, otherwise present the next one or idle
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
				in_valid <= 1'b1;
				in_data  <= pending_requests[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= !calm && $urandom_range(0, 99) < 9;
	end

	// accept requests, check results, watch for a hang
	always @(posedge clk) begin
		req_taken = arst_n && in_valid && !in_stall;
		res_taken = arst_n && out_valid && !out_stall;
		if (req_taken) begin
			void'(pending_requests.pop_front());
			apply_request(in_data);
			accepted_count++;
		end
		if (res_taken) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("result with nothing expected", out_data.in_text, 0);
			end else begin
				next_pixel = expected_pixels.pop_front();
				if (out_data.chan0_out !== next_pixel.chan0_out)
					report_mismatch("chan0_out", out_data.chan0_out, next_pixel.chan0_out);
				if (out_data.chan1_out !== next_pixel.chan1_out)
					report_mismatch("chan1_out", out_data.chan1_out, next_pixel.chan1_out);
				if (out_data.chan2_out !== next_pixel.chan2_out)
					report_mismatch("chan2_out", out_data.chan2_out, next_pixel.chan2_out);
				if (out_data.in_text !== next_pixel.in_text)
					report_mismatch("in_text", out_data.in_text, next_pixel.in_text);
			end
		end
		quiet_cycles = (req_taken || res_taken) ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		shade_table = '{255, 220, 162, 64, 0};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every gray code, the black clamp, loads outside the store,
		// area corners, just outside the area and beyond the window
		set_config(64, 48, 16, 8, ALIGN_TOP_LEFT, 50);
		push_load(0, 0, 8'd0);
		push_load(1, 0, 8'd1);
		push_load(2, 0, 8'd2);
		push_load(3, 0, 8'd3);
		push_load(4, 0, 8'd4);
		push_load(5, 0, 8'd255);
		push_load(15, 7, 8'd128);
		push_load(STORE_W, 0, 8'd2);
		push_load(0, STORE_R, 8'd1);
		push_load(COORD_MAX, COORD_MAX, 8'd255);
		push_pixel(0, 7, 8'd255, 8'd0, 8'd128);
		push_pixel(1, 7, 8'd0, 8'd255, 8'd1);
		push_pixel(2, 7, 8'd255, 8'd255, 8'd255);
		push_pixel(3, 7, 8'd0, 8'd0, 8'd0);
		push_pixel(4, 7, 8'd200, 8'd100, 8'd50);
		push_pixel(5, 7, 8'd255, 8'd127, 8'd0);
		push_pixel(15, 0, 8'd255, 8'd255, 8'd255);
		push_pixel(0, 0, 8'd0, 8'd0, 8'd0);
		push_pixel(16, 7, 8'd10, 8'd20, 8'd30);
		push_pixel(0, 8, 8'd40, 8'd50, 8'd60);
		push_pixel(63, 47, 8'd255, 8'd0, 8'd255);
		push_pixel(64, 0, 8'd1, 8'd2, 8'd3);
		push_pixel(COORD_MAX, COORD_MAX, 8'd255, 8'd255, 8'd255);

		set_config(640, 480, 100, 20, ALIGN_TOP_RIGHT, 0);
		fill_phase(PHASE_ITEMS);
		set_config(2048, 2048, 256, 32, ALIGN_BOTTOM_LEFT, 100);
		fill_phase(PHASE_ITEMS);
		set_config(1, 1, 511, 63, ALIGN_BOTTOM_RIGHT, 127);
		fill_phase(PHASE_ITEMS);
		set_config(300, 200, 511, 63, ALIGN_TOP_CENTRE, 75);
		fill_phase(PHASE_ITEMS);
		set_config(301, 99, 37, 5, ALIGN_BOTTOM_CENTRE, 33);
		fill_phase(PHASE_ITEMS);
		set_config(0, 480, 50, 10, ALIGN_SPARE_6, 50);
		fill_phase(PHASE_ITEMS);
		set_config(640, 0, 20, 4, ALIGN_SPARE_7, 100);
		fill_phase(PHASE_ITEMS);
		set_config(100, 50, 0, 0, ALIGN_TOP_LEFT, 50);
		fill_phase(PHASE_ITEMS);
		set_config(4095, 4095, 256, 32, ALIGN_TOP_CENTRE, 1);
		fill_phase(PHASE_ITEMS);
		set_config(200, 40, 200, 32, ALIGN_SPARE_6, 90);
		fill_phase(PHASE_ITEMS);
		set_config(17, 9, 300, 40, ALIGN_BOTTOM_CENTRE, 101);
		fill_phase(PHASE_ITEMS);
		repeat (3) begin
			set_config($urandom_range(1, 2048), $urandom_range(1, 2048), $urandom_range(0, 511),
				$urandom_range(0, 63), $urandom_range(0, 7), $urandom_range(0, 127));
			fill_phase(PHASE_ITEMS);
		end

		drain();
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
